[src/fvnh_pkg.sv]
`default_nettype none
package fvnh_pkg;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_SCALE_SHIFT_X = 1'b0,
    REG_SCALE_SHIFT_Z = 1'b1
  } cfg_reg_t;

  localparam int unsigned MaxShift = 12;
  localparam int unsigned FracBits = 24;
  localparam int unsigned LatW     = 32;
  localparam int unsigned FracW    = 12;
  localparam int unsigned WeightW  = 13;
  // Bits 13..43 (shifted) and bits 0..30 of the first hash word reach the 31 kept bits.
  localparam int unsigned HashW    = 44;
  localparam int unsigned ValW     = 31;
  localparam int unsigned LerpXW   = ValW + FracW;
  localparam int unsigned LerpZW   = LerpXW + FracW;

  // Z multiplier 13258953287 split into a high and a low partial product.
  localparam int unsigned MulSplit = 22;
  localparam logic [HashW-1:0] ZMulLo = 44'd758343;
  localparam logic [11:0] ZMulHi = 12'd3161;
  localparam logic [HashW-1:0] ZMul = 44'd13258953287;
  // When the z lattice index steps from the largest positive value to the most
  // negative one, the z term drops by 2^32 times the multiplier.
  localparam logic [HashW-1:0] ZWrapAdj = {ZMul[11:0], 32'd0};
  localparam logic [ValW-1:0] HashK1 = 31'd15731;
  localparam logic [ValW-1:0] HashK2 = 31'd789221;
  localparam logic [ValW-1:0] HashK3 = 31'd1376312589;

  // Fold of the first hash word: arithmetic shift by 13 xor the word, low 31 bits.
  function automatic logic [ValW-1:0] hash_fold(input logic [HashW-1:0] h);
    return h[HashW-1:13] ^ h[ValW-1:0];
  endfunction

endpackage
`default_nettype wire

[src/fvnh_if.sv]
`default_nettype none
interface fvnh_coord_if;
  logic        valid;
  logic        ready;
  logic [31:0] coord_x;
  logic [31:0] coord_z;
  modport source (output valid, coord_x, coord_z, input ready);
  modport sink (input valid, coord_x, coord_z, output ready);
endinterface

interface fvnh_height_if;
  logic       valid;
  logic       ready;
  logic [5:0] height;
  modport source (output valid, height, input ready);
  modport sink (input valid, height, output ready);
endinterface
`default_nettype wire

[src/fractal_value_noise_height_core.sv]
`default_nettype none
// Channel  | Direction | Payload
// coord    | in        | coord_x[31:0] signed, coord_z[31:0] signed
// result   | out       | height[5:0] signed
// cfg      | in        | cfg_we, cfg_index[0], cfg_data[3:0]
//
// Eleven register stages; one column enters every cycle unless a stalled result backs up the stages.
// Each stage holds while its successor is full and stalled, so bubbles close up.
// Reset clears all valid bits and sets both scale shifts to 6.
// A stalled result holds its value until the transfer completes.
module fractal_value_noise_height_core #(
  parameter int unsigned OCTAVES = 5
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [3:0]  cfg_data,
  fvnh_coord_if.sink       coord,
  fvnh_height_if.source    result
);

  localparam int unsigned Stages = 11;
  localparam int unsigned WStages = 8;
  localparam int unsigned PosW = fvnh_pkg::LatW + OCTAVES - 1;
  localparam int unsigned AccW = fvnh_pkg::LerpZW + OCTAVES - 1 + $clog2(OCTAVES + 1);
  localparam int unsigned ShW = $clog2(AccW + 1) + 1;

  logic [3:0] sx;
  logic [3:0] sz;
  logic [Stages:1] vld;
  logic [Stages:1] en;

  // Configuration writes, saturated to the largest shift.
  always_ff @(posedge clk) begin
    if (rst) begin
      sx <= 4'd6;
      sz <= 4'd6;
    end else if (cfg_we) begin
      unique case (fvnh_pkg::cfg_reg_t'(cfg_index))
        fvnh_pkg::REG_SCALE_SHIFT_X:
          sx <= (cfg_data > 4'(fvnh_pkg::MaxShift)) ? 4'(fvnh_pkg::MaxShift) : cfg_data;
        fvnh_pkg::REG_SCALE_SHIFT_Z:
          sz <= (cfg_data > 4'(fvnh_pkg::MaxShift)) ? 4'(fvnh_pkg::MaxShift) : cfg_data;
        default: ;
      endcase
    end
  end

  // A stage loads when it is empty or its content moves on.
  always_comb begin
    en[Stages] = !vld[Stages] || result.ready;
    for (int k = Stages - 1; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign coord.ready = en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) vld[1] <= coord.valid;
      for (int k = 2; k <= Stages; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // Per-octave pipeline registers.
  logic [31:0] lx1 [OCTAVES];
  logic [31:0] lz1 [OCTAVES];
  logic [fvnh_pkg::FracW-1:0]   fx   [WStages:1][OCTAVES];
  logic [fvnh_pkg::FracW-1:0]   fz   [WStages:1][OCTAVES];
  logic [fvnh_pkg::WeightW-1:0] wfx  [WStages:1][OCTAVES];
  logic [fvnh_pkg::WeightW-1:0] wfz  [WStages:1][OCTAVES];
  logic [fvnh_pkg::HashW-1:0] ax2 [OCTAVES];
  logic [fvnh_pkg::HashW-1:0] plo2 [OCTAVES];
  logic [21:0] phi2 [OCTAVES];
  logic zwrap2 [OCTAVES];
  logic [fvnh_pkg::HashW-1:0] a0_3 [OCTAVES];
  logic [fvnh_pkg::HashW-1:0] a1_3 [OCTAVES];
  logic [fvnh_pkg::HashW-1:0] b0_3 [OCTAVES];
  logic [fvnh_pkg::HashW-1:0] b1_3 [OCTAVES];
  logic [fvnh_pkg::ValW-1:0] g4 [OCTAVES][4];
  logic [fvnh_pkg::ValW-1:0] g5 [OCTAVES][4];
  logic [fvnh_pkg::ValW-1:0] g6 [OCTAVES][4];
  logic [fvnh_pkg::ValW-1:0] sq5 [OCTAVES][4];
  logic [fvnh_pkg::ValW-1:0] t6 [OCTAVES][4];
  logic [fvnh_pkg::ValW-1:0] v7 [OCTAVES][4];
  logic [fvnh_pkg::LerpXW-1:0] i8 [OCTAVES][2];
  logic [fvnh_pkg::LerpZW-1:0] v9 [OCTAVES];
  logic [AccW-1:0] acc10;
  logic [AccW-1:0] acc_next;
  logic [5:0] height_q;

  for (genvar o = 0; o < OCTAVES; o++) begin : g_oct
    logic signed [PosW-1:0] px;
    logic signed [PosW-1:0] pz;
    logic [fvnh_pkg::FracW-1:0] mx;
    logic [fvnh_pkg::FracW-1:0] mz;

    // Stage 1: scale the coordinate, split into lattice index and fraction.
    assign px = PosW'($signed(coord.coord_x)) <<< o;
    assign pz = PosW'($signed(coord.coord_z)) <<< o;
    assign mx = fvnh_pkg::FracW'((fvnh_pkg::WeightW'(1) << sx) - 1'b1);
    assign mz = fvnh_pkg::FracW'((fvnh_pkg::WeightW'(1) << sz) - 1'b1);

    always_ff @(posedge clk) begin
      if (en[1]) begin
        lx1[o] <= 32'(px >>> sx);
        lz1[o] <= 32'(pz >>> sz);
        fx[1][o] <= fvnh_pkg::FracW'(px) & mx;
        fz[1][o] <= fvnh_pkg::FracW'(pz) & mz;
        wfx[1][o] <= (fvnh_pkg::WeightW'(1) << sx) - {1'b0, fvnh_pkg::FracW'(px) & mx};
        wfz[1][o] <= (fvnh_pkg::WeightW'(1) << sz) - {1'b0, fvnh_pkg::FracW'(pz) & mz};
      end
    end

    // Interpolation weights travel with the item.
    for (genvar k = 2; k <= WStages; k++) begin : g_w
      always_ff @(posedge clk) begin
        if (en[k]) begin
          fx[k][o]  <= fx[k-1][o];
          fz[k][o]  <= fz[k-1][o];
          wfx[k][o] <= wfx[k-1][o];
          wfz[k][o] <= wfz[k-1][o];
        end
      end
    end

    // Stage 2: partial products of the z lattice index and the z multiplier.
    always_ff @(posedge clk) begin
      if (en[2]) begin
        ax2[o]    <= fvnh_pkg::HashW'($signed(lx1[o]));
        plo2[o]   <= fvnh_pkg::HashW'(fvnh_pkg::HashW'($signed(lz1[o])) * fvnh_pkg::ZMulLo);
        phi2[o]   <= 22'(lz1[o] * fvnh_pkg::ZMulHi);
        zwrap2[o] <= (lz1[o] == 32'h7fff_ffff);
      end
    end

    // Stage 3: both x and z terms for the lattice cell and its neighbors.
    // The neighbor index wraps at 32 bits before it is sign extended.
    always_ff @(posedge clk) begin
      if (en[3]) begin
        a0_3[o] <= ax2[o];
        a1_3[o] <= fvnh_pkg::HashW'($signed(ax2[o][31:0] + 32'd1));
        b0_3[o] <= plo2[o] + {phi2[o], {fvnh_pkg::MulSplit{1'b0}}};
        b1_3[o] <= plo2[o] + {phi2[o], {fvnh_pkg::MulSplit{1'b0}}} + fvnh_pkg::ZMul
                 - (zwrap2[o] ? fvnh_pkg::ZWrapAdj : '0);
      end
    end

    // Stages 4 to 7: corner hashes; corner bit 0 steps x, bit 1 steps z.
    for (genvar c = 0; c < 4; c++) begin : g_corner
      always_ff @(posedge clk) begin
        if (en[4]) begin
          g4[o][c] <= fvnh_pkg::hash_fold(((c % 2) == 1 ? a1_3[o] : a0_3[o])
                                          + ((c / 2) == 1 ? b1_3[o] : b0_3[o]));
        end
        if (en[5]) begin
          g5[o][c]  <= g4[o][c];
          sq5[o][c] <= fvnh_pkg::ValW'(g4[o][c] * g4[o][c]);
        end
        if (en[6]) begin
          g6[o][c] <= g5[o][c];
          t6[o][c] <= fvnh_pkg::ValW'(sq5[o][c] * fvnh_pkg::HashK1 + fvnh_pkg::HashK2);
        end
        if (en[7]) begin
          v7[o][c] <= fvnh_pkg::ValW'(g6[o][c] * t6[o][c] + fvnh_pkg::HashK3);
        end
      end
    end

    // Stage 8 and 9: bilinear interpolation, first along x, then along z.
    always_ff @(posedge clk) begin
      if (en[8]) begin
        i8[o][0] <= fvnh_pkg::LerpXW'(v7[o][0]) * wfx[7][o]
                  + fvnh_pkg::LerpXW'(v7[o][1]) * fx[7][o];
        i8[o][1] <= fvnh_pkg::LerpXW'(v7[o][2]) * wfx[7][o]
                  + fvnh_pkg::LerpXW'(v7[o][3]) * fx[7][o];
      end
      if (en[9]) begin
        v9[o] <= fvnh_pkg::LerpZW'(i8[o][0]) * wfz[8][o]
               + fvnh_pkg::LerpZW'(i8[o][1]) * fz[8][o];
      end
    end
  end

  // Stage 10: weighted octave sum; lower octaves carry the larger amplitude.
  always_comb begin
    acc_next = '0;
    for (int o = 0; o < OCTAVES; o++) begin
      acc_next = acc_next + (AccW'(v9[o]) << (OCTAVES - 1 - o));
    end
  end

  always_ff @(posedge clk) begin
    if (en[10]) acc10 <= acc_next;
  end

  // Stage 11: floor, divide by four, subtract 32 (a flip of the top bit).
  logic [ShW-1:0] shamt;
  logic [AccW-1:0] total;
  assign shamt = ShW'(fvnh_pkg::FracBits + OCTAVES - 1) + ShW'(sx) + ShW'(sz);
  assign total = acc10 >> shamt;

  always_ff @(posedge clk) begin
    if (en[11]) height_q <= {~total[7], total[6:2]};
  end

  assign result.valid  = vld[Stages];
  assign result.height = height_q;

endmodule
`default_nettype wire

[src/fvnh_checker.sv]
`default_nettype none
module fvnh_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [5:0] height
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(height))
    else $error("result changed while stalled");

  // With no result waiting, the pipeline can always take a column.
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

  // With downstream ready, the pipeline can always take a column.
  a_ready_when_taken: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input blocked while output drains");

endmodule

bind fractal_value_noise_height_core fvnh_checker u_fvnh_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(coord.valid),
  .in_ready(coord.ready),
  .out_valid(result.valid),
  .out_ready(result.ready),
  .height(result.height)
);
`default_nettype wire
